// ----- rtl/src_pkg.sv -----
// ----------------------------------------------------------------------------
// src_pkg: shared types and constants for the segment rectangle clipper
// Coordinate width, region codes, item structs and the region function.
// ----------------------------------------------------------------------------
package src_pkg;

  localparam int CoordBits = 16;
  localparam int MaxRounds = 4;
  // quotient magnitude saturates at 2^QuotLimit
  localparam int QuotLimit = 40;
  // dividend is |dx| * |t|, each below 2^(CoordBits+1)
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int QBits     = QuotLimit + 1;

  localparam logic [3:0] RegInside = 4'd0;
  localparam logic [3:0] RegLeft   = 4'd1;
  localparam logic [3:0] RegRight  = 4'd2;
  localparam logic [3:0] RegBelow  = 4'd4;
  localparam logic [3:0] RegBL     = 4'd5;
  localparam logic [3:0] RegBR     = 4'd6;
  localparam logic [3:0] RegAbove  = 4'd8;
  localparam logic [3:0] RegAL     = 4'd9;
  localparam logic [3:0] RegAR     = 4'd10;

  localparam logic [1:0] AddrLeft   = 2'd0;
  localparam logic [1:0] AddrBottom = 2'd1;
  localparam logic [1:0] AddrRight  = 2'd2;
  localparam logic [1:0] AddrTop    = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t seg_x0;
    coord_t seg_y0;
    coord_t seg_x1;
    coord_t seg_y1;
  } seg_in_t;

  typedef struct packed {
    logic       accepted;
    coord_t     clip_x0;
    coord_t     clip_y0;
    coord_t     clip_x1;
    coord_t     clip_y1;
    logic [3:0] start_region;
    logic [3:0] end_region;
  } seg_out_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } rect_t;

  // classified item passed from front to back
  typedef struct packed {
    seg_in_t    seg;
    logic [3:0] c0;
    logic [3:0] c1;
  } work_t;

  // region code as a priority chain
  function automatic logic [3:0] region(coord_t x, coord_t y, rect_t r);
    logic xin, yin, xl, xr, yb, yt;
    logic [3:0] c;
    xl  = x < r.left;
    xr  = x > r.right;
    yb  = y < r.bottom;
    yt  = y > r.top;
    xin = !xl && !xr;
    yin = !yb && !yt;
    if (xin && yin)     c = RegInside;
    else if (xl && yin) c = RegLeft;
    else if (xr && yin) c = RegRight;
    else if (xin && yb) c = RegBelow;
    else if (xl && yb)  c = RegBL;
    else if (xr && yb)  c = RegBR;
    else if (xin && yt) c = RegAbove;
    else if (xl && yt)  c = RegAL;
    else                c = RegAR;
    return c;
  endfunction

endpackage

// ----- rtl/segment_rectangle_clipper.sv -----
// ----------------------------------------------------------------------------
// segment_rectangle_clipper: Cohen-Sutherland segment clipper
// Clips one segment per item against a rectangle held in APB registers.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------
//   segment  | start / busy         | seg (seg_in_t)
//   result   | done (one cycle)     | result (seg_out_t)
//   config   | psel penable pwrite  | paddr pwdata prdata
//
// Each clipping round steps through evaluate, multiply, launch, a 34-bit serial
// divide and update; an item takes 0 to 4 rounds before its result is strobed.
// Reset (rst, synchronous) restores the rectangle 0..1023 on both axes.
// A two-entry queue decouples input from the clipping sequencer; busy rises
// while an item is held. Results are strobed by done for one cycle.
// ----------------------------------------------------------------------------
module segment_rectangle_clipper (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  src_pkg::seg_in_t  seg,
  output logic              busy,
  output logic              done,
  output src_pkg::seg_out_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  src_pkg::rect_t rect;
  logic           wr_en, rd_en, full, empty;
  src_pkg::work_t wr_data, rd_data;

  assign pready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect.left   <= '0;
      rect.bottom <= '0;
      rect.right  <= src_pkg::CoordBits'(1023);
      rect.top    <= src_pkg::CoordBits'(1023);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        src_pkg::AddrLeft:   rect.left   <= pwdata[src_pkg::CoordBits-1:0];
        src_pkg::AddrBottom: rect.bottom <= pwdata[src_pkg::CoordBits-1:0];
        src_pkg::AddrRight:  rect.right  <= pwdata[src_pkg::CoordBits-1:0];
        src_pkg::AddrTop:    rect.top    <= pwdata[src_pkg::CoordBits-1:0];
        default: ;
      endcase
    end
  end

  // read back, sign extended
  always_comb begin
    unique case (paddr[3:2])
      src_pkg::AddrLeft:   prdata = 32'(rect.left);
      src_pkg::AddrBottom: prdata = 32'(rect.bottom);
      src_pkg::AddrRight:  prdata = 32'(rect.right);
      src_pkg::AddrTop:    prdata = 32'(rect.top);
      default:             prdata = '0;
    endcase
  end

  src_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .seg    (seg),
    .rect   (rect),
    .busy   (busy),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .full   (full)
  );

  src_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .full   (full),
    .rd_en  (rd_en),
    .rd_data(rd_data),
    .empty  (empty)
  );

  src_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .rd_data(rd_data),
    .rd_en  (rd_en),
    .rect   (rect),
    .done   (done),
    .result (result)
  );

endmodule

// ----- rtl/src_front.sv -----
// ----------------------------------------------------------------------------
// src_front: input stage
// Accept a segment, compute both region codes, and push it into the queue.
// ----------------------------------------------------------------------------
module src_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  src_pkg::seg_in_t  seg,
  input  src_pkg::rect_t    rect,
  output logic              busy,
  output logic              wr_en,
  output src_pkg::work_t    wr_data,
  input  logic              full
);

  logic             held;
  src_pkg::seg_in_t seg_q;

  assign busy = held;

  // hold one item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && !held) begin
      held <= 1'b1;
    end else if (held && !full) begin
      held <= 1'b0;
    end
    if (start && !held) begin
      seg_q <= seg;
    end
  end

  // classify the held item
  assign wr_en           = held && !full;
  assign wr_data.seg     = seg_q;
  assign wr_data.c0      = src_pkg::region(seg_q.seg_x0, seg_q.seg_y0, rect);
  assign wr_data.c1      = src_pkg::region(seg_q.seg_x1, seg_q.seg_y1, rect);

endmodule

// ----- rtl/src_fifo.sv -----
// ----------------------------------------------------------------------------
// src_fifo: two-entry queue between the front and back stages
// Registered storage with read and write pointers.
// ----------------------------------------------------------------------------
module src_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  src_pkg::work_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output src_pkg::work_t rd_data,
  output logic           empty
);

  src_pkg::work_t mem [2];
  logic           wp, rp;
  logic [1:0]     cnt;

  assign full    = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign rd_data = mem[rp];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

// ----- rtl/src_divider.sv -----
// ----------------------------------------------------------------------------
// src_divider: restoring divider, one quotient bit per cycle
// Unsigned dividend over unsigned divisor, quotient saturated at 2^40.
// ----------------------------------------------------------------------------
module src_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [src_pkg::ProdBits-1:0]       dividend,
  input  logic [src_pkg::DiffBits-1:0]       divisor,
  output logic                               done,
  output logic [src_pkg::QBits-1:0]          quot
);

  localparam int NB = src_pkg::ProdBits;
  localparam int CB = $clog2(NB + 1);
  localparam int WB = (NB > src_pkg::QBits) ? NB : src_pkg::QBits;

  logic [NB-1:0]                 dvd;
  logic [src_pkg::DiffBits:0]    rem;
  logic [src_pkg::DiffBits-1:0]  dsr;
  logic [NB-1:0]                 q;
  logic [WB-1:0]                 q_wide;
  logic [CB-1:0]                 cnt;
  logic                          run;
  logic [src_pkg::DiffBits:0]    shifted;
  logic                          ge;

  assign shifted = {rem[src_pkg::DiffBits-1:0], dvd[NB-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign q_wide  = WB'(q);

  // saturate when any bit at or above the limit is set
  always_comb begin
    if (|(q_wide >> src_pkg::QuotLimit)) begin
      quot = src_pkg::QBits'(1) << src_pkg::QuotLimit;
    end else begin
      quot = q_wide[src_pkg::QBits-1:0];
    end
  end

  // shift in one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CB'(NB);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (go) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      q   <= '0;
    end else if (run) begin
      dvd <= dvd << 1;
      rem <= ge ? shifted - {1'b0, dsr} : shifted;
      q   <= {q[NB-2:0], ge};
    end
  end

endmodule

// ----- rtl/src_back.sv -----
// ----------------------------------------------------------------------------
// src_back: clipping sequencer
// Pop a classified item, run up to four clipping rounds, emit the result.
// ----------------------------------------------------------------------------
module src_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  src_pkg::work_t    rd_data,
  output logic              rd_en,
  input  src_pkg::rect_t    rect,
  output logic              done,
  output src_pkg::seg_out_t result
);

  localparam int CB = src_pkg::CoordBits;
  localparam int DB = src_pkg::DiffBits;
  localparam int PB = src_pkg::ProdBits;
  localparam int QB = src_pkg::QBits;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t state;
  src_pkg::coord_t x0, y0, x1, y1;
  logic [3:0] c0, c1, s0, s1;
  logic [2:0] rnd;
  logic       side;        // 1: moving first endpoint
  logic       use_y;       // 1: edge is horizontal (above/below)
  src_pkg::coord_t edge_v;
  logic signed [DB-1:0] da, dt, dd;
  logic       neg;
  logic [PB-1:0] prod;
  logic       div_go, div_done;
  logic [QB-1:0] quot;

  logic [3:0] c_sel;
  logic       sel_y, take0;
  src_pkg::coord_t sel_edge;
  logic signed [DB-1:0] base_n, a_n, t_n, d_n;
  logic signed [QB:0] sq;
  logic signed [QB+1:0] sum;
  src_pkg::coord_t sat;
  logic [DB-1:0] ua, ut, ud;

  // pick the endpoint and edge for this round
  always_comb begin
    take0 = c0 != src_pkg::RegInside;
    c_sel = take0 ? c0 : c1;
    sel_y = c_sel[3] || c_sel[2];
    if (c_sel[3])      sel_edge = rect.top;
    else if (c_sel[2]) sel_edge = rect.bottom;
    else if (c_sel[1]) sel_edge = rect.right;
    else               sel_edge = rect.left;
    if (sel_y) begin
      a_n = DB'(x1) - DB'(x0);
      t_n = DB'(sel_edge) - DB'(y0);
      d_n = DB'(y1) - DB'(y0);
    end else begin
      a_n = DB'(y1) - DB'(y0);
      t_n = DB'(sel_edge) - DB'(x0);
      d_n = DB'(x1) - DB'(x0);
    end
    base_n = sel_y ? DB'(x0) : DB'(y0);
  end

  assign ua = da[DB-1] ? DB'(-da) : DB'(da);
  assign ut = dt[DB-1] ? DB'(-dt) : DB'(dt);
  assign ud = dd[DB-1] ? DB'(-dd) : DB'(dd);

  // new coordinate with saturation
  always_comb begin
    logic signed [QB:0] qs;
    qs  = {1'b0, quot};
    sq  = (dd == '0) ? '0 : (neg ? -qs : qs);
    sum = (QB+2)'(sq) + (QB+2)'(base_n);
    if (sum > (QB+2)'(2 ** (CB - 1) - 1))       sat = {1'b0, {(CB-1){1'b1}}};
    else if (sum < -(QB+2)'(2 ** (CB - 1)))     sat = {1'b1, {(CB-1){1'b0}}};
    else                                         sat = sum[CB-1:0];
  end

  src_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(prod),
    .divisor (ud),
    .done    (div_done),
    .quot    (quot)
  );

  assign rd_en  = state == S_IDLE && !empty;
  assign div_go = state == S_DIV;

  // sequence the rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) state <= S_EVAL;
        end
        S_EVAL: begin
          if ((c0 == '0 && c1 == '0) || (c0 & c1) != '0 ||
              rnd == 3'(src_pkg::MaxRounds)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_DIV;
        S_DIV:  state <= S_WAIT;
        S_WAIT: begin
          if (div_done) state <= S_UPD;
        end
        S_UPD:  state <= S_EVAL;
        default: state <= S_IDLE;
      endcase
    end
    case (state)
      S_IDLE: begin
        x0 <= rd_data.seg.seg_x0;
        y0 <= rd_data.seg.seg_y0;
        x1 <= rd_data.seg.seg_x1;
        y1 <= rd_data.seg.seg_y1;
        c0 <= rd_data.c0;
        c1 <= rd_data.c1;
        s0 <= rd_data.c0;
        s1 <= rd_data.c1;
        rnd <= '0;
      end
      S_EVAL: begin
        side   <= take0;
        use_y  <= sel_y;
        edge_v <= sel_edge;
        da     <= a_n;
        dt     <= t_n;
        dd     <= d_n;
        neg    <= (a_n[DB-1] ^ t_n[DB-1]) ^ d_n[DB-1];
      end
      S_MUL: begin
        prod <= PB'(ua) * PB'(ut);
      end
      S_UPD: begin
        rnd <= rnd + 1'b1;
        if (side) begin
          x0 <= use_y ? sat : edge_v;
          y0 <= use_y ? edge_v : sat;
          c0 <= src_pkg::region(use_y ? sat : edge_v, use_y ? edge_v : sat, rect);
        end else begin
          x1 <= use_y ? sat : edge_v;
          y1 <= use_y ? edge_v : sat;
          c1 <= src_pkg::region(use_y ? sat : edge_v, use_y ? edge_v : sat, rect);
        end
      end
      default: ;
    endcase
  end

  // form the result item
  always_comb begin
    logic acc;
    acc = c0 == '0 && c1 == '0;
    result.accepted     = acc;
    result.clip_x0      = acc ? x0 : '0;
    result.clip_y0      = acc ? y0 : '0;
    result.clip_x1      = acc ? x1 : '0;
    result.clip_y1      = acc ? y1 : '0;
    result.start_region = s0;
    result.end_region   = s1;
  end

endmodule

// ----- tb/segment_rectangle_clipper_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_rectangle_clipper_tb: self-checking bench for the segment clipper
// Drives segments through start/busy, predicts each clipped result in the
// bench and compares it field by field with the done-strobed output. The
// clip rectangle is reprogrammed over APB between phases, including full
// range, inverted and single-point rectangles.
// ----------------------------------------------------------------------------
module segment_rectangle_clipper_tb;

  localparam int  HalfPeriod = 6;
  localparam int  StallLimit = 5000;
  localparam int  DrainWait  = 200;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  src_pkg::seg_in_t  seg = '0;
  logic     busy, done;
  src_pkg::seg_out_t result;
  logic     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  src_pkg::rect_t    clip_rect;
  src_pkg::seg_out_t pending_clips[$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  int       idle_pct = 0;

  segment_rectangle_clipper uut (
    .clk(clk), .rst(rst), .start(start), .seg(seg), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #HalfPeriod clk = ~clk;

  // region code of one point against the current rectangle
  function automatic logic [3:0] outcode(longint x, longint y);
    bit xl, xr, yb, yt, xin, yin;
    xl  = x < longint'(clip_rect.left);
    xr  = x > longint'(clip_rect.right);
    yb  = y < longint'(clip_rect.bottom);
    yt  = y > longint'(clip_rect.top);
    xin = !xl && !xr;
    yin = !yb && !yt;
    if (xin && yin)     return src_pkg::RegInside;
    if (xl && yin)      return src_pkg::RegLeft;
    if (xr && yin)      return src_pkg::RegRight;
    if (xin && yb)      return src_pkg::RegBelow;
    if (xl && yb)       return src_pkg::RegBL;
    if (xr && yb)       return src_pkg::RegBR;
    if (xin && yt)      return src_pkg::RegAbove;
    if (xl && yt)       return src_pkg::RegAL;
    return src_pkg::RegAR;
  endfunction

  // edge intersection: base + dx * t / dy, truncated, saturated to a coord
  function automatic longint edge_cross(longint base, longint dx, longint t, longint dy);
    longint q, v;
    q = (dy == 0) ? 0 : (dx * t) / dy;
    v = base + q;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // clip one segment with the current rectangle
  function automatic src_pkg::seg_out_t clip_segment(src_pkg::seg_in_t s);
    longint x0, y0, x1, y1, nx, ny, l, b, r, t;
    logic [3:0] c0, c1, c;
    src_pkg::seg_out_t o;
    bit acc;
    l = clip_rect.left;  b = clip_rect.bottom;
    r = clip_rect.right; t = clip_rect.top;
    x0 = s.seg_x0; y0 = s.seg_y0; x1 = s.seg_x1; y1 = s.seg_y1;
    c0 = outcode(x0, y0);
    c1 = outcode(x1, y1);
    o = '0;
    o.start_region = c0;
    o.end_region = c1;
    acc = 1'b0;
    for (int rnd = 0; rnd <= src_pkg::MaxRounds; rnd++) begin
      if (c0 == src_pkg::RegInside && c1 == src_pkg::RegInside) begin
        acc = 1'b1;
        break;
      end
      if ((c0 & c1) != 0 || rnd == src_pkg::MaxRounds) break;
      c = (c0 != src_pkg::RegInside) ? c0 : c1;
      if (c[3]) begin
        nx = edge_cross(x0, x1 - x0, t - y0, y1 - y0); ny = t;
      end else if (c[2]) begin
        nx = edge_cross(x0, x1 - x0, b - y0, y1 - y0); ny = b;
      end else if (c[1]) begin
        ny = edge_cross(y0, y1 - y0, r - x0, x1 - x0); nx = r;
      end else begin
        ny = edge_cross(y0, y1 - y0, l - x0, x1 - x0); nx = l;
      end
      if (c0 != src_pkg::RegInside) begin
        x0 = nx; y0 = ny; c0 = outcode(x0, y0);
      end else begin
        x1 = nx; y1 = ny; c1 = outcode(x1, y1);
      end
    end
    o.accepted = acc;
    if (acc) begin
      o.clip_x0 = src_pkg::coord_t'(x0); o.clip_y0 = src_pkg::coord_t'(y0);
      o.clip_x1 = src_pkg::coord_t'(x1); o.clip_y1 = src_pkg::coord_t'(y1);
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    error_count++;
  endtask

  // check each strobed result against the oldest expectation
  always @(posedge clk) begin
    src_pkg::seg_out_t want;
    if (!rst && done) begin
      if (pending_clips.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = pending_clips.pop_front();
        if (result.accepted !== want.accepted)
          report_mismatch("accepted", result.accepted, want.accepted);
        if (result.clip_x0 !== want.clip_x0)
          report_mismatch("clip_x0", result.clip_x0, want.clip_x0);
        if (result.clip_y0 !== want.clip_y0)
          report_mismatch("clip_y0", result.clip_y0, want.clip_y0);
        if (result.clip_x1 !== want.clip_x1)
          report_mismatch("clip_x1", result.clip_x1, want.clip_x1);
        if (result.clip_y1 !== want.clip_y1)
          report_mismatch("clip_y1", result.clip_y1, want.clip_y1);
        if (result.start_region !== want.start_region)
          report_mismatch("start_region", result.start_region, want.start_region);
        if (result.end_region !== want.end_region)
          report_mismatch("end_region", result.end_region, want.end_region);
      end
    end
  end

  // watchdog: count cycles with no item accepted and no result strobed
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("segment_rectangle_clipper_tb failed");
      $finish;
    end
  end

  // send one item; the sender idles each cycle with chance idle_pct percent
  task automatic send_segment(logic [15:0] x0, logic [15:0] y0,
                              logic [15:0] x1, logic [15:0] y1);
    src_pkg::seg_in_t s;
    s.seg_x0 = x0; s.seg_y0 = y0; s.seg_x1 = x1; s.seg_y1 = y1;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    seg <= s;
    do @(posedge clk); while (busy);
    pending_clips = {pending_clips, clip_segment(s)};
  endtask

  task automatic drop_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // wait until every expected result has come, then let the block settle
  task automatic drain();
    drop_start();
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = {{16{value[15]}}, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_rect(int l, int b, int r, int t);
    drain();
    write_reg(src_pkg::AddrLeft, l[15:0]);
    write_reg(src_pkg::AddrBottom, b[15:0]);
    write_reg(src_pkg::AddrRight, r[15:0]);
    write_reg(src_pkg::AddrTop, t[15:0]);
    clip_rect.left = src_pkg::coord_t'(l); clip_rect.bottom = src_pkg::coord_t'(b);
    clip_rect.right = src_pkg::coord_t'(r); clip_rect.top = src_pkg::coord_t'(t);
  endtask

  // coordinate near the rectangle on one axis, or anywhere, or an extreme
  function automatic logic [15:0] pick_coord(int lo_edge, int hi_edge);
    int lo, hi, k;
    k = $urandom_range(9);
    if (k < 2) return 16'($urandom);
    if (k == 2) return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    lo = (lo_edge < hi_edge ? lo_edge : hi_edge) - 400;
    hi = (lo_edge < hi_edge ? hi_edge : lo_edge) + 400;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  task automatic test_directed_default();
    send_segment(16'd10, 16'd10, 16'd500, 16'd900);     // fully inside
    send_segment(-16'sd5, 16'd10, -16'sd50, 16'd900);   // both left: reject
    send_segment(-16'sd100, 16'd512, 16'd2000, 16'd512); // crosses left and right
    send_segment(16'd512, -16'sd100, 16'd512, 16'd2000); // vertical through
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff); // extreme diagonal
    send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_segment(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_segment(16'd0, 16'd0, 16'd1023, 16'd1023);     // corners exactly
    send_segment(-16'sd10, 16'd1030, 16'd1030, -16'sd10); // corner regions
    send_segment(-16'sd10, 16'd1100, 16'd20, 16'd2000); // misses above-left
    send_segment(16'd2000, 16'd1100, 16'd500, 16'd500); // above-right inward
    send_segment(16'd500, 16'd500, -16'sd300, -16'sd50); // second endpoint out
    send_segment(-16'sd1, 16'd1024, 16'd1024, 16'd2048); // both above: reject
  endtask

  task automatic test_directed_inverted();
    // inverted rectangle: zero divisors and unreachable inside
    send_segment(16'd50, 16'd50, 16'd50, 16'd900);
    send_segment(16'd50, 16'd50, 16'd900, 16'd50);
    send_segment(16'h8000, 16'd7, 16'h7fff, 16'd7);
    send_segment(16'd200, 16'h8000, 16'd800, 16'h7fff);
    send_segment(16'd300, 16'd300, 16'd300, 16'd300);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_segment(pick_coord(clip_rect.left, clip_rect.right),
                   pick_coord(clip_rect.bottom, clip_rect.top),
                   pick_coord(clip_rect.left, clip_rect.right),
                   pick_coord(clip_rect.bottom, clip_rect.top));
    end
  endtask

  // run random items under each idling pattern
  task automatic test_idle_patterns(int count);
    idle_pct = 0;  test_random(count / 3);
    idle_pct = 82; test_random(count / 3);
    idle_pct = 6;  test_random(count / 3);
    idle_pct = 0;
  endtask

  initial begin
    clip_rect.left = 16'sd0;    clip_rect.bottom = 16'sd0;
    clip_rect.right = 16'sd1023; clip_rect.top = 16'sd1023;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed_default();
    test_idle_patterns(240);
    set_rect(-32768, -32768, 32767, 32767);
    test_idle_patterns(150);
    set_rect(-200, 100, 300, 150);
    test_idle_patterns(240);
    set_rect(700, 900, 100, -50);
    test_directed_inverted();
    test_idle_patterns(150);
    set_rect(5, -5, 5, -5);
    test_idle_patterns(150);
    set_rect(32000, -32768, 32767, -32000);
    test_idle_patterns(150);
    set_rect(int'($urandom_range(20000)) - 20000, int'($urandom_range(20000)) - 20000,
             int'($urandom_range(20000)), int'($urandom_range(20000)));
    test_idle_patterns(300);
    drain();

    if (error_count == 0) begin
      $display("segment_rectangle_clipper_tb passed");
    end else begin
      $display("segment_rectangle_clipper_tb failed");
    end
    $finish;
  end

endmodule

// ----- segment_rectangle_clipper.f -----
rtl/src_pkg.sv
rtl/src_front.sv
rtl/src_fifo.sv
rtl/src_divider.sv
rtl/src_back.sv
rtl/segment_rectangle_clipper.sv
tb/segment_rectangle_clipper_tb.sv
